>>> src/lcnh_pkg.sv
// shared types and constants for the line and circle nearest-hit block
package lcnh_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;

   typedef enum logic [1:0] {
      ST_MISS     = 2'd0,
      ST_TANGENT  = 2'd1,
      ST_CROSSING = 2'd2,
      ST_VERTICAL = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] orig_x;
      logic signed [DATA_WIDTH-1:0] orig_y;
      logic signed [DATA_WIDTH-1:0] dir_x;
      logic signed [DATA_WIDTH-1:0] dir_y;
      logic signed [DATA_WIDTH-1:0] center_x;
      logic signed [DATA_WIDTH-1:0] center_y;
      logic [DATA_WIDTH-2:0]        radius;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [DATA_WIDTH-1:0] distance;
      logic                  saturated;
   } rsp_type;

endpackage

>>> src/lcnh_front.sv
// front pipeline: offsets, dot and cross products, exact discriminant test
module lcnh_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  lcnh_pkg::req_type                   in_req,
   output logic                                out_valid,
   output lcnh_pkg::status_type                out_status,
   output logic [lcnh_pkg::PROD_WIDTH-1:0]     out_dot,
   output logic [lcnh_pkg::PROD_WIDTH-1:0]     out_cross,
   output logic [lcnh_pkg::PROD_WIDTH-1:0]     out_l2,
   output logic [lcnh_pkg::DATA_WIDTH-2:0]     out_radius,
   output logic [lcnh_pkg::PROD_WIDTH-1:0]     out_r2
);

   localparam int W  = lcnh_pkg::DATA_WIDTH;
   localparam int PW = lcnh_pkg::PROD_WIDTH;
   localparam int QW = 2 * PW;

   // magnitude of a signed sum given as sign and magnitude pairs
   function automatic logic [PW-1:0] sm_sum(input logic na, input logic [PW-1:0] ma,
                                             input logic nb, input logic [PW-1:0] mb);
      logic [PW-1:0] res;
      if (na == nb) begin
         res = ma + mb;
      end else if (ma > mb) begin
         res = ma - mb;
      end else begin
         res = mb - ma;
      end
      return res;
   endfunction

   // stage 1: offsets and magnitudes
   logic signed [W:0] ex_in, ey_in;
   logic v1_ff, vert1_ff, sdx1_ff, sdy1_ff, sex1_ff, sey1_ff;
   logic [W-1:0] mdx1_ff, mdy1_ff;
   logic [W:0]   mex1_ff, mey1_ff;
   logic [W-2:0] rad1_ff;

   assign ex_in = {in_req.orig_x[W-1], in_req.orig_x} - {in_req.center_x[W-1], in_req.center_x};
   assign ey_in = {in_req.orig_y[W-1], in_req.orig_y} - {in_req.center_y[W-1], in_req.center_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      vert1_ff <= (in_req.dir_x == '0);
      sdx1_ff  <= in_req.dir_x[W-1];
      sdy1_ff  <= in_req.dir_y[W-1];
      sex1_ff  <= ex_in[W];
      sey1_ff  <= ey_in[W];
      mdx1_ff  <= in_req.dir_x[W-1] ? W'(-in_req.dir_x) : W'(in_req.dir_x);
      mdy1_ff  <= in_req.dir_y[W-1] ? W'(-in_req.dir_y) : W'(in_req.dir_y);
      mex1_ff  <= ex_in[W] ? (W+1)'(-ex_in) : (W+1)'(ex_in);
      mey1_ff  <= ey_in[W] ? (W+1)'(-ey_in) : (W+1)'(ey_in);
      rad1_ff  <= in_req.radius;
   end

   // stage 2: component products
   logic [2*W:0] pxe_full, pye_full, pxy_full, pyx_full;
   logic v2_ff, vert2_ff, nda2_ff, ndb2_ff, nca2_ff, ncb2_ff;
   logic [PW-1:0] pxe2_ff, pye2_ff, pxy2_ff, pyx2_ff, pxx2_ff, pyy2_ff, r2_2_ff;
   logic [W-2:0]  rad2_ff;

   assign pxe_full = mdx1_ff * mex1_ff;
   assign pye_full = mdy1_ff * mey1_ff;
   assign pxy_full = mdx1_ff * mey1_ff;
   assign pyx_full = mdy1_ff * mex1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      vert2_ff <= vert1_ff;
      nda2_ff  <= sdx1_ff ^ sex1_ff;
      ndb2_ff  <= sdy1_ff ^ sey1_ff;
      nca2_ff  <= sdx1_ff ^ sey1_ff;
      ncb2_ff  <= ~(sdy1_ff ^ sex1_ff);
      pxe2_ff  <= pxe_full[PW-1:0];
      pye2_ff  <= pye_full[PW-1:0];
      pxy2_ff  <= pxy_full[PW-1:0];
      pyx2_ff  <= pyx_full[PW-1:0];
      pxx2_ff  <= mdx1_ff * mdx1_ff;
      pyy2_ff  <= mdy1_ff * mdy1_ff;
      r2_2_ff  <= rad1_ff * rad1_ff;
      rad2_ff  <= rad1_ff;
   end

   // stage 3: dot, cross and squared length
   logic v3_ff, vert3_ff;
   logic [PW-1:0] dot3_ff, cross3_ff, l2_3_ff, r2_3_ff;
   logic [W-2:0]  rad3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      vert3_ff  <= vert2_ff;
      dot3_ff   <= sm_sum(nda2_ff, pxe2_ff, ndb2_ff, pye2_ff);
      cross3_ff <= sm_sum(nca2_ff, pxy2_ff, ncb2_ff, pyx2_ff);
      l2_3_ff   <= pxx2_ff + pyy2_ff;
      r2_3_ff   <= r2_2_ff;
      rad3_ff   <= rad2_ff;
   end

   // stage 4: half-word partial products of cross^2 and r^2 * l2
   logic v4_ff, vert4_ff;
   logic [PW-1:0] dot4_ff, cross4_ff, l2_4_ff, r2_4_ff;
   logic [W-2:0]  rad4_ff;
   logic [PW-1:0] qhh4_ff, qhl4_ff, qll4_ff, mhh4_ff, mhl4_ff, mlh4_ff, mll4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      vert4_ff  <= vert3_ff;
      dot4_ff   <= dot3_ff;
      cross4_ff <= cross3_ff;
      l2_4_ff   <= l2_3_ff;
      r2_4_ff   <= r2_3_ff;
      rad4_ff   <= rad3_ff;
      qhh4_ff   <= cross3_ff[PW-1:W] * cross3_ff[PW-1:W];
      qhl4_ff   <= cross3_ff[PW-1:W] * cross3_ff[W-1:0];
      qll4_ff   <= cross3_ff[W-1:0] * cross3_ff[W-1:0];
      mhh4_ff   <= r2_3_ff[PW-1:W] * l2_3_ff[PW-1:W];
      mhl4_ff   <= r2_3_ff[PW-1:W] * l2_3_ff[W-1:0];
      mlh4_ff   <= r2_3_ff[W-1:0] * l2_3_ff[PW-1:W];
      mll4_ff   <= r2_3_ff[W-1:0] * l2_3_ff[W-1:0];
   end

   // stage 5: full-width squares
   logic v5_ff, vert5_ff;
   logic [PW-1:0] dot5_ff, cross5_ff, l2_5_ff, r2_5_ff;
   logic [W-2:0]  rad5_ff;
   logic [QW-1:0] csq5_ff, rsq5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      vert5_ff  <= vert4_ff;
      dot5_ff   <= dot4_ff;
      cross5_ff <= cross4_ff;
      l2_5_ff   <= l2_4_ff;
      r2_5_ff   <= r2_4_ff;
      rad5_ff   <= rad4_ff;
      csq5_ff   <= {qhh4_ff, qll4_ff} + (QW'(qhl4_ff) << (W + 1));
      rsq5_ff   <= {mhh4_ff, mll4_ff} + ((QW'(mhl4_ff) + QW'(mlh4_ff)) << W);
   end

   // stage 6: classify
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v5_ff;
      end
      if (vert5_ff) begin
         out_status <= lcnh_pkg::ST_VERTICAL;
      end else if (csq5_ff > rsq5_ff) begin
         out_status <= lcnh_pkg::ST_MISS;
      end else if (csq5_ff == rsq5_ff) begin
         out_status <= lcnh_pkg::ST_TANGENT;
      end else begin
         out_status <= lcnh_pkg::ST_CROSSING;
      end
      out_dot    <= dot5_ff;
      out_cross  <= cross5_ff;
      out_l2     <= l2_5_ff;
      out_r2     <= r2_5_ff;
      out_radius <= rad5_ff;
   end

endmodule

>>> src/lcnh_isqrt.sv
// pipelined integer square root, one result bit per stage
module lcnh_isqrt #(
   parameter int IN_WIDTH   = 64,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [IN_WIDTH-1:0]     in_rad,
   input  logic [SIDE_WIDTH-1:0]   in_side,
   output logic                    out_valid,
   output logic [IN_WIDTH/2-1:0]   out_root,
   output logic [SIDE_WIDTH-1:0]   out_side
);

   localparam int STEPS = IN_WIDTH / 2;
   localparam int RW    = STEPS + 2;

   logic                  valid_ff [STEPS];
   logic [STEPS-1:0]      root_ff  [STEPS];
   logic [SIDE_WIDTH-1:0] side_ff  [STEPS];
   logic [RW-1:0]         rem_ff   [STEPS-1];
   logic [IN_WIDTH-1:0]   rad_ff   [STEPS-1];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                  valid_src;
      logic [STEPS-1:0]      root_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic [RW-1:0]         rem_src;
      logic [IN_WIDTH-1:0]   rad_src;
      logic [RW+1:0]         cur, trial;
      logic                  take;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign root_src  = '0;
         assign side_src  = in_side;
         assign rem_src   = '0;
         assign rad_src   = in_rad;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign root_src  = root_ff[i-1];
         assign side_src  = side_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign rad_src   = rad_ff[i-1];
      end

      // trial subtract of 4*root + 1 from the next two radicand bits
      assign cur   = {rem_src, rad_src[IN_WIDTH-1 -: 2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_src;
         end
         root_ff[i] <= {root_src[STEPS-2:0], take};
         side_ff[i] <= side_src;
      end

      if (i < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[i] <= take ? RW'(cur - trial) : RW'(cur);
            rad_ff[i] <= rad_src << 2;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

>>> src/lcnh_div2.sv
// pipelined restoring divider: two numerators over one shared divisor
module lcnh_div2 #(
   parameter int NUM_WIDTH  = 64,
   parameter int DEN_WIDTH  = 32,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [NUM_WIDTH-1:0]  in_num_a,
   input  logic [NUM_WIDTH-1:0]  in_num_b,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [NUM_WIDTH-1:0]  out_quo_a,
   output logic [NUM_WIDTH-1:0]  out_quo_b,
   output logic [SIDE_WIDTH-1:0] out_side
);

   localparam int STEPS = NUM_WIDTH;

   logic                  valid_ff [STEPS];
   logic [NUM_WIDTH-1:0]  qa_ff    [STEPS];
   logic [NUM_WIDTH-1:0]  qb_ff    [STEPS];
   logic [SIDE_WIDTH-1:0] side_ff  [STEPS];
   logic [DEN_WIDTH-1:0]  ra_ff    [STEPS-1];
   logic [DEN_WIDTH-1:0]  rb_ff    [STEPS-1];
   logic [NUM_WIDTH-1:0]  na_ff    [STEPS-1];
   logic [NUM_WIDTH-1:0]  nb_ff    [STEPS-1];
   logic [DEN_WIDTH-1:0]  den_ff   [STEPS-1];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                  valid_src;
      logic [NUM_WIDTH-1:0]  qa_src, qb_src, na_src, nb_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic [DEN_WIDTH-1:0]  ra_src, rb_src, den_src;
      logic [DEN_WIDTH:0]    cur_a, cur_b;
      logic                  take_a, take_b;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign qa_src    = '0;
         assign qb_src    = '0;
         assign na_src    = in_num_a;
         assign nb_src    = in_num_b;
         assign side_src  = in_side;
         assign ra_src    = '0;
         assign rb_src    = '0;
         assign den_src   = in_den;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign qa_src    = qa_ff[i-1];
         assign qb_src    = qb_ff[i-1];
         assign na_src    = na_ff[i-1];
         assign nb_src    = nb_ff[i-1];
         assign side_src  = side_ff[i-1];
         assign ra_src    = ra_ff[i-1];
         assign rb_src    = rb_ff[i-1];
         assign den_src   = den_ff[i-1];
      end

      assign cur_a  = {ra_src, na_src[NUM_WIDTH-1]};
      assign cur_b  = {rb_src, nb_src[NUM_WIDTH-1]};
      assign take_a = (cur_a >= {1'b0, den_src});
      assign take_b = (cur_b >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_src;
         end
         qa_ff[i]   <= {qa_src[NUM_WIDTH-2:0], take_a};
         qb_ff[i]   <= {qb_src[NUM_WIDTH-2:0], take_b};
         side_ff[i] <= side_src;
      end

      if (i < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            ra_ff[i]  <= take_a ? DEN_WIDTH'(cur_a - {1'b0, den_src}) : DEN_WIDTH'(cur_a);
            rb_ff[i]  <= take_b ? DEN_WIDTH'(cur_b - {1'b0, den_src}) : DEN_WIDTH'(cur_b);
            na_ff[i]  <= na_src << 1;
            nb_ff[i]  <= nb_src << 1;
            den_ff[i] <= den_src;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo_a = qa_ff[STEPS-1];
   assign out_quo_b = qb_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

>>> src/lcnh_back.sv
// back pipeline: half chord root, nearer distance and saturation
module lcnh_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  lcnh_pkg::status_type             in_status,
   input  logic [lcnh_pkg::PROD_WIDTH-1:0]  in_along,
   input  logic [lcnh_pkg::PROD_WIDTH-1:0]  in_perp,
   input  logic [lcnh_pkg::DATA_WIDTH-2:0]  in_radius,
   input  logic [lcnh_pkg::PROD_WIDTH-1:0]  in_r2,
   output logic                             out_valid,
   output lcnh_pkg::rsp_type                out_rsp
);

   localparam int W  = lcnh_pkg::DATA_WIDTH;
   localparam int PW = lcnh_pkg::PROD_WIDTH;
   localparam int SW = 2 + PW;

   // stage 1: perpendicular distance squared, clamp test
   logic          v1_ff, clip1_ff;
   logic [1:0]    st1_ff;
   logic [PW-1:0] s1_ff, r2_1_ff, pp1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      st1_ff   <= in_status;
      s1_ff    <= in_along;
      r2_1_ff  <= in_r2;
      clip1_ff <= (in_perp >= PW'(in_radius));
      pp1_ff   <= in_perp[W-2:0] * in_perp[W-2:0];
   end

   // stage 2: radicand of the half chord
   logic          v2_ff;
   logic [1:0]    st2_ff;
   logic [PW-1:0] s2_ff, rad2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      st2_ff  <= st1_ff;
      s2_ff   <= s1_ff;
      rad2_ff <= clip1_ff ? '0 : r2_1_ff - pp1_ff;
   end

   logic          hv;
   logic [W-1:0]  half;
   logic [SW-1:0] hside;
   logic [1:0]    hst_bits;
   logic [PW-1:0] hs;

   lcnh_isqrt #(
      .IN_WIDTH   (PW),
      .SIDE_WIDTH (SW)
   ) u_half (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rad    (rad2_ff),
      .in_side   ({st2_ff, s2_ff}),
      .out_valid (hv),
      .out_root  (half),
      .out_side  (hside)
   );

   assign {hst_bits, hs} = hside;

   // final stage: nearer crossing and clip to output range
   lcnh_pkg::status_type hst;
   logic [PW-1:0]        diff, near_dist;
   logic                 over;

   assign hst  = lcnh_pkg::status_type'(hst_bits);
   assign diff = (hs > PW'(half)) ? hs - PW'(half) : PW'(half) - hs;

   always_comb begin
      unique case (hst)
         lcnh_pkg::ST_TANGENT:  near_dist = hs;
         lcnh_pkg::ST_CROSSING: near_dist = diff;
         default:               near_dist = '0;
      endcase
   end

   assign over = (near_dist[PW-1:W] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= hv;
      end
      out_rsp.status    <= hst;
      out_rsp.distance  <= over ? '1 : near_dist[W-1:0];
      out_rsp.saturated <= over;
   end

endmodule

>>> src/line_circle_nearest_hit.sv
// top level of the line and circle nearest-hit pipeline
//
// request side: a line (origin, direction) and a circle (centre, radius) in
//   signed fixed point arrive on req_data and are taken when start is high;
//   busy is held low, so a new request is taken in every cycle
// result side: rsp_strobe is high for one cycle with status, distance to the
//   nearer crossing and a saturation flag on rsp_data; there is no back-pressure
// delay: set by the bit-per-stage pipelines of the two square roots and
//   the shared divider
// throughput: one request per cycle, one result per request, in order
// flow: six front stages for the exact discriminant test, a root for the line
//   length, a divider for the along and across distances, two stages for the
//   half chord radicand, its root, and a final clipping stage
// a vertical direction gives status vertical with zero distance; a miss gives
//   zero distance
// reset: synchronous, clears every valid bit so nothing in flight survives;
//   no warm-up is needed afterwards
module line_circle_nearest_hit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lcnh_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lcnh_pkg::rsp_type rsp_data
);

   localparam int W       = lcnh_pkg::DATA_WIDTH;
   localparam int PW      = lcnh_pkg::PROD_WIDTH;
   localparam int LATENCY = 6 + W + PW + 2 + W + 1;

   // side data widths for the root and divider pipelines
   localparam int S1W = 2 + PW + PW + (W - 1) + PW;
   localparam int S2W = 2 + (W - 1) + PW;

   // never stalls: the pipeline moves on every cycle
   assign busy = 1'b0;

   // front: exact classification
   logic                 fv;
   lcnh_pkg::status_type fst;
   logic [PW-1:0]        fdot, fcross, fl2, fr2;
   logic [W-2:0]         frad;

   lcnh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start & ~busy),
      .in_req     (req_data),
      .out_valid  (fv),
      .out_status (fst),
      .out_dot    (fdot),
      .out_cross  (fcross),
      .out_l2     (fl2),
      .out_radius (frad),
      .out_r2     (fr2)
   );

   // line length root
   logic           lv;
   logic [W-1:0]   len;
   logic [S1W-1:0] lside;
   logic [1:0]     lst;
   logic [PW-1:0]  ldot, lcross, lr2;
   logic [W-2:0]   lrad;

   lcnh_isqrt #(
      .IN_WIDTH   (PW),
      .SIDE_WIDTH (S1W)
   ) u_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fv),
      .in_rad    (fl2),
      .in_side   ({fst, fdot, fcross, frad, fr2}),
      .out_valid (lv),
      .out_root  (len),
      .out_side  (lside)
   );

   assign {lst, ldot, lcross, lrad, lr2} = lside;

   // along and across distances by the line length
   logic           dv;
   logic [PW-1:0]  along, perp;
   logic [S2W-1:0] dside;
   logic [1:0]     dst;
   logic [W-2:0]   drad;
   logic [PW-1:0]  dr2;

   lcnh_div2 #(
      .NUM_WIDTH  (PW),
      .DEN_WIDTH  (W),
      .SIDE_WIDTH (S2W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lv),
      .in_num_a  (ldot),
      .in_num_b  (lcross),
      .in_den    (len),
      .in_side   ({lst, lrad, lr2}),
      .out_valid (dv),
      .out_quo_a (along),
      .out_quo_b (perp),
      .out_side  (dside)
   );

   assign {dst, drad, dr2} = dside;

   // half chord and result
   lcnh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv),
      .in_status (lcnh_pkg::status_type'(dst)),
      .in_along  (along),
      .in_perp   (perp),
      .in_radius (drad),
      .in_r2     (dr2),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

`ifndef SYNTH
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("request did not produce a result at the fixed latency");

   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");

   a_no_hit_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == lcnh_pkg::ST_MISS ||
                      rsp_data.status == lcnh_pkg::ST_VERTICAL))
      |-> (rsp_data.distance == '0 && !rsp_data.saturated))
      else $error("miss or vertical result carries a distance");

   a_sat_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |-> (rsp_data.distance == '1))
      else $error("saturated distance not at full scale");
`endif

endmodule

>>> verif/line_circle_nearest_hit_checker.sv
// request and result monitor with nearest-hit predictor and scoreboard
`timescale 1ns / 100ps

module line_circle_nearest_hit_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  lcnh_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  lcnh_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                status_seen [4],
   output int                clipped_seen
);

   lcnh_pkg::rsp_type hit_queue [$];

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic lcnh_pkg::rsp_type predict_hit(input lcnh_pkg::req_type q);
      logic signed [127:0] dx, dy, ex, ey, dot, crs;
      logic [127:0] dotm, crsm, l2, r2, lhs, rhs;
      logic [63:0] len, s, p, h, d;
      lcnh_pkg::rsp_type o;
      o.status = lcnh_pkg::ST_MISS;
      o.distance = '0;
      o.saturated = 1'b0;
      if (q.dir_x == 0) begin
         o.status = lcnh_pkg::ST_VERTICAL;
         return o;
      end
      dx = q.dir_x;
      dy = q.dir_y;
      ex = 128'(signed'(q.orig_x)) - 128'(signed'(q.center_x));
      ey = 128'(signed'(q.orig_y)) - 128'(signed'(q.center_y));
      dot = dx * ex + dy * ey;
      crs = dx * ey - dy * ex;
      dotm = dot < 0 ? -dot : dot;
      crsm = crs < 0 ? -crs : crs;
      l2 = dx * dx + dy * dy;
      r2 = {97'd0, q.radius} * {97'd0, q.radius};
      lhs = crsm * crsm;
      rhs = r2 * l2;
      if (lhs > rhs) return o;
      len = root_floor(l2[63:0]);
      s = dotm[63:0] / len;
      if (lhs == rhs) begin
         o.status = lcnh_pkg::ST_TANGENT;
         d = s;
      end else begin
         o.status = lcnh_pkg::ST_CROSSING;
         p = crsm[63:0] / len;
         // rounded across distance at or beyond the radius: no half chord
         h = (p >= {33'd0, q.radius}) ? 64'd0 : root_floor(r2[63:0] - p * p);
         d = s > h ? s - h : h - s;
      end
      if (d > 64'hFFFF_FFFF) begin
         d = 64'hFFFF_FFFF;
         o.saturated = 1'b1;
      end
      o.distance = d[31:0];
      return o;
   endfunction

   always @(posedge clock) begin
      lcnh_pkg::rsp_type want;
      if (reset) begin
         hit_queue.delete();
         mismatch_count <= 0;
         clipped_seen <= 0;
         for (int i = 0; i < 4; i++) status_seen[i] <= 0;
      end else begin
         if (start && !busy) hit_queue.push_back(predict_hit(req_data));
         if (rsp_strobe) begin
            if (hit_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("error: result with nothing outstanding: %p", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = hit_queue.pop_front();
               status_seen[want.status] <= status_seen[want.status] + 1;
               if (want.saturated) clipped_seen <= clipped_seen + 1;
               if (want.status != rsp_data.status || want.distance != rsp_data.distance
                   || want.saturated != rsp_data.saturated) begin
                  if (mismatch_count < 10)
                     $display("error: status %0d/%0d distance %h/%h saturated %b/%b (exp/act)",
                              want.status, rsp_data.status, want.distance,
                              rsp_data.distance, want.saturated, rsp_data.saturated);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count <= hit_queue.size();
   end

endmodule

>>> verif/line_circle_nearest_hit_tb.sv
// stimulus and verdict for the line and circle nearest-hit block
`timescale 1ns / 100ps

module line_circle_nearest_hit_tb;

   localparam int ONE = 32'h0001_0000;   // 1.0 in Q16.16
   localparam int DRAIN_CYCLES = 160;    // longer than the pipeline depth

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   lcnh_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   lcnh_pkg::rsp_type rsp_data;

   int mismatch_count, pending_count, clipped_seen;
   int status_seen [4];
   int sent_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   line_circle_nearest_hit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   line_circle_nearest_hit_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .status_seen(status_seen), .clipped_seen(clipped_seen)
   );

   // present a request at the current edge and hold it until taken,
   // then idle for a random gap; a zero gap keeps start high throughout
   task automatic issue_request(input lcnh_pkg::req_type q, input bit no_gaps);
      int gap;
      start <= 1'b1;
      req_data <= q;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      sent_count++;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // pick an edge value or a random one
   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'h1;
         4: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic lcnh_pkg::req_type make_request(input int kind);
      lcnh_pkg::req_type q;
      int span, rad;
      q.orig_x = $urandom; q.orig_y = $urandom; q.dir_x = $urandom; q.dir_y = $urandom;
      q.center_x = $urandom; q.center_y = $urandom; q.radius = 31'($urandom);
      case (kind)
         0: ;  // fully random, mostly misses
         1: begin
            // well-formed geometry near the circle, mostly crossings
            span = 1 << $urandom_range(4, 22);
            rad = $urandom_range(1, span);
            q.center_x = $signed($urandom_range(0, 2 * span)) - span;
            q.center_y = $signed($urandom_range(0, 2 * span)) - span;
            q.radius = 31'(rad);
            q.orig_x = q.center_x + $signed($urandom_range(0, 4 * rad)) - 2 * rad;
            q.orig_y = q.center_y + $signed($urandom_range(0, 4 * rad)) - 2 * rad;
            q.dir_x = $signed($urandom_range(0, 2 * ONE)) - ONE;
            q.dir_y = $signed($urandom_range(0, 2 * ONE)) - ONE;
            if (q.dir_x == 0) q.dir_x = 1;
         end
         2: begin
            // horizontal line grazing the top or bottom: exact tangent
            q.radius = 31'($urandom_range(0, 1 << 24));
            q.center_y = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            q.orig_y = $urandom_range(0, 1) ? q.center_y + q.radius : q.center_y - q.radius;
            q.dir_y = 0;
            q.dir_x = $urandom_range(1, ONE) * ($urandom_range(0, 1) ? 1 : -1);
         end
         3: q.dir_x = 0;  // vertical direction
         4: begin
            // origin and circle at opposite ends of the x range to push the distance past the range
            q.orig_x = 32'h8000_0000 + $urandom_range(0, 255);
            q.center_x = 32'h7FFF_FF00 + $urandom_range(0, 255);
            q.orig_y = $urandom_range(0, 255);
            q.center_y = $urandom_range(0, 255);
            q.radius = 31'($urandom_range(0, 1 << 20));
            q.dir_x = $urandom_range(1, 255);
            q.dir_y = $urandom_range(0, 3);
         end
         default: begin
            q.orig_x = corner_word(); q.orig_y = corner_word();
            q.dir_x = corner_word(); q.dir_y = corner_word();
            q.center_x = corner_word(); q.center_y = corner_word();
            q.radius = 31'(corner_word());
         end
      endcase
      return q;
   endfunction

   function automatic lcnh_pkg::req_type line_req(input int ox, oy, dx, dy, cx, cy, r);
      lcnh_pkg::req_type q;
      q.orig_x = ox; q.orig_y = oy; q.dir_x = dx; q.dir_y = dy;
      q.center_x = cx; q.center_y = cy; q.radius = 31'(r);
      return q;
   endfunction

   initial begin
      lcnh_pkg::req_type directed [$];
      int kind, burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit circle at the origin, line along x from x = -2: two crossings
      directed.push_back(line_req(-2 * ONE, 0, ONE, 0, 0, 0, ONE));
      // same line touching the top of the circle: tangent
      directed.push_back(line_req(-2 * ONE, ONE, ONE, 0, 0, 0, ONE));
      // clear of the circle: miss
      directed.push_back(line_req(-2 * ONE, 3 * ONE, ONE, 0, 0, 0, ONE));
      // vertical direction, dir y ignored
      directed.push_back(line_req(0, 0, 0, ONE, 0, 0, ONE));
      directed.push_back(line_req(0, 0, 0, 0, 0, 0, 0));
      // origin at the centre, negative diagonal direction
      directed.push_back(line_req(5 * ONE, 5 * ONE, -ONE, -ONE, 5 * ONE, 5 * ONE, 2 * ONE));
      // zero radius through the centre: tangent of a point circle
      directed.push_back(line_req(0, 0, ONE, 0, 3 * ONE, 0, 0));
      // smallest direction
      directed.push_back(line_req(-ONE, 0, 1, 1, 0, 0, ONE));
      // extremes of every field
      directed.push_back(line_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
      directed.push_back(line_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
      directed.push_back(line_req(32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 0, 1));
      directed.push_back(line_req(32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF));
      directed.push_back(line_req(-1, -1, -1, -1, 0, 0, 31'h7FFF_FFFF));
      // across distance rounding right onto the radius
      directed.push_back(line_req(0, 3, 3, 1, 0, 0, 3));
      foreach (directed[i]) issue_request(directed[i], i < 6);

      // random part, with some back-to-back bursts
      while (sent_count < 1000 + directed.size()) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : 1;
         repeat (burst) begin
            kind = $urandom_range(0, 99);
            kind = kind < 8 ? 0 : kind < 60 ? 1 : kind < 72 ? 2 : kind < 78 ? 3
                 : kind < 88 ? 4 : 5;
            issue_request(make_request(kind), burst > 1);
         end
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d miss, %0d tangent, %0d crossing, %0d vertical",
               sent_count, status_seen[lcnh_pkg::ST_MISS], status_seen[lcnh_pkg::ST_TANGENT],
               status_seen[lcnh_pkg::ST_CROSSING], status_seen[lcnh_pkg::ST_VERTICAL]);
      $display("%0d clipped distances, %0d mismatches, %0d results missing",
               clipped_seen, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout");
      $display("TEST FAILED");
      $finish;
   end

endmodule
